// ===== hdl/smpq_pkg.sv =====
package smpq_pkg;

    // Queue geometry.
    localparam int DEPTH      = 32;
    localparam int TAG_WIDTH  = 16;
    localparam int PRI_WIDTH  = 16;
    localparam int CNT_WIDTH  = $clog2(DEPTH + 1);
    localparam int ACT_WIDTH  = 2;
    localparam int STAT_WIDTH = 2;

    // Action codes of a request.
    localparam logic [ACT_WIDTH-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_WIDTH-1:0] ACT_POP    = 2'd1;
    localparam logic [ACT_WIDTH-1:0] ACT_CLEAR  = 2'd2;

    // Status codes of a response.
    localparam logic [STAT_WIDTH-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_WIDTH-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_WIDTH-1:0] ST_FULL  = 2'd2;

    localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);

    typedef struct packed {
        logic [ACT_WIDTH-1:0]        action;
        logic [TAG_WIDTH-1:0]        item_tag;
        logic signed [PRI_WIDTH-1:0] priority_req;
    } smpq_req_t;

    typedef struct packed {
        logic [STAT_WIDTH-1:0] status;
        logic [TAG_WIDTH-1:0]  popped_tag;
        logic [TAG_WIDTH-1:0]  head_tag;
        logic [TAG_WIDTH-1:0]  tail_tag;
        logic [CNT_WIDTH-1:0]  entry_count;
    } smpq_rsp_t;

    // Contents of one slot of the chain.
    typedef struct packed {
        logic                        valid;
        logic [TAG_WIDTH-1:0]        tag;
        logic signed [PRI_WIDTH-1:0] pri;
    } smpq_entry_t;

    // Command broadcast to every cell in the cycle a request is accepted.
    typedef struct packed {
        logic                        insert;
        logic                        pop;
        logic                        clear;
        logic [TAG_WIDTH-1:0]        tag;
        logic signed [PRI_WIDTH-1:0] pri;
    } smpq_cmd_t;

endpackage

// ===== hdl/smpq_cell.sv =====
// One slot of the sorted chain. On an insert a cell whose item ranks behind
// the new one either takes the new item or its left neighbor's item; on a pop
// every cell takes its right neighbor's item; a clear empties every cell.
module smpq_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  smpq_pkg::smpq_cmd_t   cmd,
    input  smpq_pkg::smpq_entry_t left_entry,
    input  logic                 left_gt,
    input  smpq_pkg::smpq_entry_t right_entry,
    output smpq_pkg::smpq_entry_t entry,
    output smpq_pkg::smpq_entry_t entry_next,
    output logic                 gt
);

    logic                        valid_reg;
    logic [smpq_pkg::TAG_WIDTH-1:0] tag_reg;
    logic signed [smpq_pkg::PRI_WIDTH-1:0] pri_reg;

    assign entry.valid = valid_reg;
    assign entry.tag   = tag_reg;
    assign entry.pri   = pri_reg;

    // An empty slot, or one holding a strictly larger priority, lies behind
    // the new item. Equal priorities stay ahead so ties keep arrival order.
    assign gt = !valid_reg || (cmd.pri < pri_reg);

    always_comb
    begin
        entry_next = entry;
        if (cmd.clear)
        begin
            entry_next.valid = 1'b0;
        end
        else if (cmd.pop)
        begin
            entry_next = right_entry;
        end
        else if (cmd.insert && gt)
        begin
            if (left_gt)
            begin
                entry_next = left_entry;
            end
            else
            begin
                entry_next.valid = 1'b1;
                entry_next.tag   = cmd.tag;
                entry_next.pri   = cmd.pri;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= entry_next.tag;
        pri_reg <= entry_next.pri;
    end

endmodule

// ===== hdl/stable_min_priority_queue.sv =====
// Stable minimum priority queue of tagged items.
//
// A request on the req channel carries an action (insert, pop or clear), a
// tag and a signed priority. Every accepted request yields exactly one
// response on the rsp channel with a status, the tag removed by a pop, and
// the head tag, tail tag and item count after the action. The lowest
// priority value is at the head; equal priorities leave in arrival order.
// Inserting into a full queue drops the item and reports full; popping an
// empty queue reports empty.
//
// The items sit in a row of identical cells, one per slot. All cells compare
// the new priority against their own in parallel and shift right or left by
// one slot in the same cycle, so the fill does not slow a request down.
// The response is registered: it appears in the cycle after acceptance, and a
// new request can be accepted every cycle while the response is not stalled.
//
// Reset empties the queue and drops any pending response. While the receiver
// stalls a pending response, req_stall is raised; it falls in the cycle the
// response is taken, so a new request can enter in that same cycle.
module stable_min_priority_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  smpq_pkg::smpq_req_t  req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output smpq_pkg::smpq_rsp_t  rsp
);

    logic accept;
    logic full;
    logic empty;
    logic do_insert;
    logic do_pop;
    logic do_clear;
    logic append;

    logic [smpq_pkg::CNT_WIDTH-1:0] count_reg;
    logic [smpq_pkg::CNT_WIDTH-1:0] count_next;
    logic [smpq_pkg::TAG_WIDTH-1:0] tail_tag_reg;
    logic [smpq_pkg::TAG_WIDTH-1:0] tail_tag_next;
    logic signed [smpq_pkg::PRI_WIDTH-1:0] tail_pri_reg;
    logic signed [smpq_pkg::PRI_WIDTH-1:0] tail_pri_next;

    logic               rsp_valid_reg;
    smpq_pkg::smpq_rsp_t rsp_reg;
    smpq_pkg::smpq_rsp_t rsp_next;

    smpq_pkg::smpq_cmd_t   cmd;
    smpq_pkg::smpq_entry_t entry_q    [smpq_pkg::DEPTH];
    smpq_pkg::smpq_entry_t entry_next [smpq_pkg::DEPTH];
    logic [smpq_pkg::DEPTH-1:0] gt;

    // A single response register: a new request may enter when it is empty
    // or being drained in this cycle.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign full  = (count_reg == smpq_pkg::CNT_FULL);
    assign empty = (count_reg == '0);

    assign do_insert = accept && (req.action == smpq_pkg::ACT_INSERT) && !full;
    assign do_pop    = accept && (req.action == smpq_pkg::ACT_POP) && !empty;
    assign do_clear  = accept && (req.action == smpq_pkg::ACT_CLEAR);

    assign cmd.insert = do_insert;
    assign cmd.pop    = do_pop;
    assign cmd.clear  = do_clear;
    assign cmd.tag    = req.item_tag;
    assign cmd.pri    = req.priority_req;

    // The chain of slots; slot 0 is the head.
    generate
        for (genvar i = 0; i < smpq_pkg::DEPTH; i++)
        begin : g_cell
            smpq_pkg::smpq_entry_t left_entry;
            smpq_pkg::smpq_entry_t right_entry;
            logic                 left_gt;

            if (i == 0)
            begin : g_head
                assign left_entry = '0;
                assign left_gt    = 1'b0;
            end
            else
            begin : g_mid
                assign left_entry = entry_q[i-1];
                assign left_gt    = gt[i-1];
            end

            if (i == smpq_pkg::DEPTH - 1)
            begin : g_tail
                assign right_entry = '0;
            end
            else
            begin : g_inner
                assign right_entry = entry_q[i+1];
            end

            smpq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_entry  (left_entry),
                .left_gt     (left_gt),
                .right_entry (right_entry),
                .entry       (entry_q[i]),
                .entry_next  (entry_next[i]),
                .gt          (gt[i])
            );
        end
    endgenerate

    // The tail only changes when a new item lands behind every queued item.
    // The tail holds the largest priority, so one compare against it decides.
    assign append = empty || !(req.priority_req < tail_pri_reg);

    always_comb
    begin
        count_next    = count_reg;
        tail_tag_next = tail_tag_reg;
        tail_pri_next = tail_pri_reg;
        if (do_clear)
        begin
            count_next = '0;
        end
        else if (do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
        else if (do_insert)
        begin
            count_next = count_reg + 1'b1;
            if (append)
            begin
                tail_tag_next = req.item_tag;
                tail_pri_next = req.priority_req;
            end
        end
    end

    always_comb
    begin
        rsp_next.status = smpq_pkg::ST_DONE;
        if ((req.action == smpq_pkg::ACT_INSERT) && full)
        begin
            rsp_next.status = smpq_pkg::ST_FULL;
        end
        else if ((req.action == smpq_pkg::ACT_POP) && empty)
        begin
            rsp_next.status = smpq_pkg::ST_EMPTY;
        end
        rsp_next.popped_tag  = do_pop ? entry_q[0].tag : '0;
        rsp_next.head_tag    = (count_next != '0) ? entry_next[0].tag : '0;
        rsp_next.tail_tag    = (count_next != '0) ? tail_tag_next : '0;
        rsp_next.entry_count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset; the tail is only shown when the
    // count is nonzero, and every fill starts with an append.
    always_ff @(posedge clk)
    begin
        tail_tag_reg <= tail_tag_next;
        tail_pri_reg <= tail_pri_next;
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hdl/smpq_checker.sv =====
module smpq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input smpq_pkg::smpq_rsp_t  rsp
);

    // The count never exceeds the number of slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.entry_count <= smpq_pkg::CNT_FULL))
        else $error("entry count above queue depth");

    // An empty queue shows zero head and tail tags.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.entry_count == '0)) |->
            ((rsp.head_tag == '0) && (rsp.tail_tag == '0)))
        else $error("nonzero head or tail on empty queue");

    // A dropped insert is only reported on a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == smpq_pkg::ST_FULL)) |->
            (rsp.entry_count == smpq_pkg::CNT_FULL))
        else $error("insert dropped while queue not full");

    // A pop on an empty queue removes nothing and leaves it empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == smpq_pkg::ST_EMPTY)) |->
            ((rsp.entry_count == '0) && (rsp.popped_tag == '0)))
        else $error("empty pop reported on nonempty queue");

    // A stalled response holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");

endmodule

bind stable_min_priority_queue smpq_checker u_smpq_checker (.*);
